FILE: design/qips_pkg.sv
// Shared types and constants for the probability search unit.
// No dependencies; used by every module of the block.
package qips_pkg;

   localparam int POS_WIDTH   = 6;
   localparam int FRAC_WIDTH  = 16;
   localparam int SCORE_WIDTH = 32;
   localparam int GEN_WIDTH   = 16;
   localparam int BITS_WIDTH  = 64;

   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_REPORT = 1'b1;

   localparam logic signed [SCORE_WIDTH-1:0] SCORE_MIN = 32'sh8000_0000;
   localparam logic signed [SCORE_WIDTH-1:0] SCORE_MAX = 32'sh7FFF_FFFF;
   localparam logic [GEN_WIDTH-1:0]          GEN_MAX   = 16'hFFFF;
   localparam logic [15:0]                   ROT_STEP_RESET = 16'd26;

   // per-cell update control
   typedef struct packed {
      logic rotate;
      logic best_bit;
      logic worst_bit;
   } cell_ctrl_type;

   // one result transaction
   typedef struct packed {
      logic                          sampled_bit;
      logic signed [SCORE_WIDTH-1:0] best_value;
      logic [BITS_WIDTH-1:0]         best_bits;
      logic [GEN_WIDTH-1:0]          best_found_in;
      logic [GEN_WIDTH-1:0]          generation_count;
   } result_type;

endpackage

FILE: design/qips_cell.sv
// One probability cell: holds one bit's probability, rotates it toward the
// best solution at generation end and compares it for sampling. Uses qips_pkg.
module qips_cell #(
   parameter int FRAC_BITS = 16,
   parameter int INDEX     = 0
) (
   input  logic                               clock,
   input  logic                               reset,
   input  qips_pkg::cell_ctrl_type            ctrl,
   input  logic [FRAC_BITS:0]                 theta,
   input  logic [qips_pkg::POS_WIDTH-1:0]     sample_pos,
   input  logic [qips_pkg::FRAC_WIDTH-1:0]    sample_frac,
   output logic                               hit
);

   localparam int PW = FRAC_BITS + 1;
   localparam int CW = FRAC_BITS + qips_pkg::FRAC_WIDTH + 1;
   localparam logic [PW-1:0] ONE  = PW'(1) << FRAC_BITS;
   localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);
   localparam logic [qips_pkg::POS_WIDTH-1:0] MY_POS = qips_pkg::POS_WIDTH'(INDEX);

   logic [PW-1:0] prob_ff, prob_in;
   logic [PW-1:0] down_mirror, down_next, up_mirror, up_next;

   always_comb begin
      down_mirror = (prob_ff > HALF) ? ONE - prob_ff : prob_ff;
      down_next   = (down_mirror > theta) ? down_mirror - theta : '0;
      up_mirror   = (prob_ff < HALF) ? ONE - prob_ff : prob_ff;
      up_next     = (theta >= ONE - up_mirror) ? ONE : up_mirror + theta;

      prob_in = prob_ff;
      if (ctrl.rotate) begin
         if (!ctrl.best_bit && ctrl.worst_bit) begin
            prob_in = down_next;
         end else if (ctrl.best_bit && !ctrl.worst_bit) begin
            prob_in = up_next;
         end
      end
   end

   // p * 2^16 > frac * 2^FRAC_BITS, exact across both formats
   assign hit = (sample_pos == MY_POS) &&
                ((CW'(prob_ff) << qips_pkg::FRAC_WIDTH) > (CW'(sample_frac) << FRAC_BITS));

   always_ff @(posedge clock) begin
      if (reset) begin
         prob_ff <= HALF;
      end else begin
         prob_ff <= prob_in;
      end
   end

endmodule

FILE: design/qips_out_buffer.sv
// Output register with a skid entry for result transactions.
// Uses qips_pkg::result_type.
module qips_out_buffer (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  qips_pkg::result_type push_data,
   output logic                 full,
   output logic                 out_valid,
   input  logic                 out_stall,
   output qips_pkg::result_type out_data
);

   logic                 main_valid_ff, main_valid_in;
   logic                 skid_valid_ff, skid_valid_in;
   qips_pkg::result_type main_ff, main_in;
   qips_pkg::result_type skid_ff, skid_in;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (!main_valid_ff || !out_stall) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_in       = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

   // push only arrives while the skid entry is empty
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

FILE: design/quantum_inspired_probability_search_unit.sv
// Probability-vector search unit: a row of probability cells plus best/worst records.
// Throughput: 1 transaction per cycle while req_stall is low; each accepted result
// is registered in the output buffer. On generation end all cells rotate in parallel.
// A two-entry output buffer accepts one more transaction while a result is stalled.
// Synchronous reset: probabilities 0.5, bits/counters 0, scores min/max, theta 26.
// Depends on qips_pkg, qips_cell and qips_out_buffer.
module quantum_inspired_probability_search_unit #(
   parameter int SOLUTION_BITS  = 64,
   parameter int PROB_FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_func,
   input  logic [5:0]          req_bit_position,
   input  logic [15:0]         req_random_fraction,
   input  logic [63:0]         req_candidate_bits,
   input  logic signed [31:0]  req_candidate_fitness,
   input  logic                req_generation_end,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_sampled_bit,
   output logic signed [31:0]  rsp_best_value,
   output logic [63:0]         rsp_best_bits,
   output logic [15:0]         rsp_best_found_in,
   output logic [15:0]         rsp_generation_count,
   input  logic                csr_wr_en,
   input  logic [15:0]         csr_wr_data
);

   localparam int SB = SOLUTION_BITS;
   localparam int PW = PROB_FRAC_BITS + 1;
   localparam int TW = qips_pkg::FRAC_WIDTH + PROB_FRAC_BITS;

   logic [15:0]        rot_step_ff;
   logic [SB-1:0]      best_bits_ff, best_bits_in;
   logic [SB-1:0]      worst_bits_ff, worst_bits_in;
   logic signed [31:0] best_score_ff, best_score_in;
   logic signed [31:0] worst_score_ff, worst_score_in;
   logic [15:0]        best_gen_ff, best_gen_in;
   logic [15:0]        gen_ff, gen_in;

   logic                    accept, report, rotate, buf_full;
   logic [SB-1:0]           cand;
   logic [TW-1:0]           theta_wide;
   logic [PW-1:0]           theta;
   logic [SB-1:0]           hits;
   qips_pkg::cell_ctrl_type cell_ctrl [SB];
   qips_pkg::result_type    result, rsp_data;

   assign req_stall  = buf_full;
   assign accept     = req_valid && !buf_full;
   assign report     = accept && (req_func == qips_pkg::FUNC_REPORT);
   assign rotate     = report && req_generation_end;
   assign cand       = req_candidate_bits[SB-1:0];
   assign theta_wide = TW'(rot_step_ff) << PROB_FRAC_BITS;
   assign theta      = PW'(theta_wide >> qips_pkg::FRAC_WIDTH);

   always_comb begin
      best_bits_in   = best_bits_ff;
      best_score_in  = best_score_ff;
      best_gen_in    = best_gen_ff;
      worst_bits_in  = worst_bits_ff;
      worst_score_in = worst_score_ff;
      gen_in         = gen_ff;
      if (report) begin
         if (req_candidate_fitness > best_score_ff) begin
            // a negative winner is recorded as the empty solution at zero
            if (req_candidate_fitness >= 0) begin
               best_bits_in  = cand;
               best_score_in = req_candidate_fitness;
            end else begin
               best_bits_in  = '0;
               best_score_in = '0;
            end
            best_gen_in = gen_ff;
         end
         if (req_candidate_fitness < worst_score_ff) begin
            worst_bits_in  = cand;
            worst_score_in = req_candidate_fitness;
         end
         if (req_generation_end) begin
            worst_score_in = qips_pkg::SCORE_MAX;
            if (gen_ff != qips_pkg::GEN_MAX) begin
               gen_in = gen_ff + 16'd1;
            end
         end
      end
   end

   for (genvar i = 0; i < SB; i++) begin : g_cell
      // rotation sees the records after this transaction's update
      assign cell_ctrl[i] = '{rotate: rotate, best_bit: best_bits_in[i],
                              worst_bit: worst_bits_in[i]};
      qips_cell #(
         .FRAC_BITS (PROB_FRAC_BITS),
         .INDEX     (i)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .theta       (theta),
         .sample_pos  (req_bit_position),
         .sample_frac (req_random_fraction),
         .hit         (hits[i])
      );
   end

   always_comb begin
      result.sampled_bit      = (req_func == qips_pkg::FUNC_SAMPLE) && (|hits);
      result.best_value       = best_score_in;
      result.best_bits        = qips_pkg::BITS_WIDTH'(best_bits_in);
      result.best_found_in    = best_gen_in;
      result.generation_count = gen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_step_ff    <= qips_pkg::ROT_STEP_RESET;
         best_bits_ff   <= '0;
         best_score_ff  <= qips_pkg::SCORE_MIN;
         worst_bits_ff  <= '0;
         worst_score_ff <= qips_pkg::SCORE_MAX;
         best_gen_ff    <= '0;
         gen_ff         <= '0;
      end else begin
         if (csr_wr_en) begin
            rot_step_ff <= csr_wr_data;
         end
         best_bits_ff   <= best_bits_in;
         best_score_ff  <= best_score_in;
         worst_bits_ff  <= worst_bits_in;
         worst_score_ff <= worst_score_in;
         best_gen_ff    <= best_gen_in;
         gen_ff         <= gen_in;
      end
   end

   qips_out_buffer u_out_buffer (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_sampled_bit      = rsp_data.sampled_bit;
   assign rsp_best_value       = rsp_data.best_value;
   assign rsp_best_bits        = rsp_data.best_bits;
   assign rsp_best_found_in    = rsp_data.best_found_in;
   assign rsp_generation_count = rsp_data.generation_count;

endmodule
